>>> src/vgnc_pkg.sv
// ---------------------------------------------------------------------------
// Voxel grid thinning package
// Shared word types, status codes and register indexes for the voxel grid
// nearest-to-centre thinning block.
// ---------------------------------------------------------------------------
package vgnc_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Z  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CELL_SIZE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CELLS_X   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CELLS_Y   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_CELLS_Z   = 3'd6;

	localparam logic [30:0] CELL_SIZE_RST = 31'd328;
	localparam logic [16:0] CELLS_RST     = 17'd16;

	localparam logic MODE_FETCH = 1'b1;

	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_REPLACE = 3'd1;
	localparam logic [2:0] ST_KEEP    = 3'd2;
	localparam logic [2:0] ST_OUTSIDE = 3'd3;
	localparam logic [2:0] ST_DRAIN   = 3'd4;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic signed [31:0] z_coord;
		logic        [31:0] point_id;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] kept_id;
		logic [15:0] cell_number;
		logic        last;
	} res_t;

	typedef struct packed {
		logic occ_rd;
		logic occ_we;
		logic dat_rd;
		logic dat_we;
	} mem_ctl_t;

endpackage

>>> src/vgnc_divider.sv
// ---------------------------------------------------------------------------
// Voxel grid axis divider
// Restoring divider giving one quotient bit per cycle: cell coordinate and
// remainder of a non-negative offset divided by the cell size.
// ---------------------------------------------------------------------------
module vgnc_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [30:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [30:0] remainder
);

	localparam logic [4:0] LAST_STEP = 5'd31;

	logic        run_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] dq_q;
	logic [30:0] rem_q;
	logic [30:0] dvs_q;
	logic [31:0] trial;
	logic [31:0] diff;
	logic        ge;

	assign trial = {rem_q, dq_q[31]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			// The partial remainder stays below the divisor, so 31 bits hold it.
			rem_q <= ge ? diff[30:0] : trial[30:0];
			dq_q  <= {dq_q[30:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

>>> src/vgnc_cell_store.sv
// ---------------------------------------------------------------------------
// Voxel grid cell store
// Occupancy bitmap and per-cell kept point memory, both synchronous with a
// registered read port and one address each.
// ---------------------------------------------------------------------------
module vgnc_cell_store #(
	parameter int WB  = 32,
	parameter int AW  = 11,
	parameter int NW  = 2048,
	parameter int CW  = 16,
	parameter int DEP = 65536,
	parameter int DW  = 96
) (
	input  logic                clk,
	input  vgnc_pkg::mem_ctl_t  ctl,
	input  logic [AW-1:0]       occ_addr,
	input  logic [WB-1:0]       occ_wdata,
	output logic [WB-1:0]       occ_rdata,
	input  logic [CW-1:0]       dat_addr,
	input  logic [DW-1:0]       dat_wdata,
	output logic [DW-1:0]       dat_rdata
);

	import vgnc_pkg::*;

	logic [WB-1:0] occ_mem [NW];
	logic [DW-1:0] dat_mem [DEP];

	always_ff @(posedge clk) begin
		if (ctl.occ_we) begin
			occ_mem[occ_addr] <= occ_wdata;
		end
		if (ctl.occ_rd) begin
			occ_rdata <= occ_mem[occ_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.dat_we) begin
			dat_mem[dat_addr] <= dat_wdata;
		end
		if (ctl.dat_rd) begin
			dat_rdata <= dat_mem[dat_addr];
		end
	end

endmodule

>>> src/voxel_grid_nearest_center_downsample_unit.sv
// ---------------------------------------------------------------------------
// Voxel grid nearest-to-centre thinning unit
// Insert: the axis dividers, then S_OFF, S_MUL, S_SUM and S_CHK, then S_UPD; a point
// outside the grid is answered from S_CHK without the S_UPD step.
// Fetch: S_SCAN walks bitmap words to a set bit, then S_DOUT; no scan on an empty grid.
// One word is handled at a time; busy stays high until its result is strobed, but
// not for a fetch on an empty grid. After reset a clearing pass of one bitmap word a
// cycle runs with busy high; configuration writes are taken throughout.
// ---------------------------------------------------------------------------
module voxel_grid_nearest_center_downsample_unit #(
	parameter int MAX_CELLS = 65536,
	parameter int ID_WIDTH  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  vgnc_pkg::cmd_t                      cmd,
	output logic                                done,
	output vgnc_pkg::res_t                      result,
	input  logic                                cfg_we,
	input  logic [vgnc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [vgnc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	import vgnc_pkg::*;

	localparam int CW   = $clog2(MAX_CELLS);
	localparam int WB   = (MAX_CELLS >= 64) ? 32 : 4;
	localparam int WBL  = $clog2(WB);
	localparam int AW   = CW - WBL;
	localparam int NW   = (MAX_CELLS + WB - 1) / WB;
	localparam int DW   = ID_WIDTH + 64;
	localparam int CNTW = CW + 1;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_OFF   = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_SUM   = 4'd5;
	localparam logic [3:0] S_CHK   = 4'd6;
	localparam logic [3:0] S_UPD   = 4'd7;
	localparam logic [3:0] S_SCAN  = 4'd8;
	localparam logic [3:0] S_DOUT  = 4'd9;

	function automatic logic [30:0] half_off(input logic [30:0] rem, input logic [30:0] cs);
		logic signed [32:0] tw;
		tw = $signed({1'b0, rem, 1'b0}) - $signed({2'b0, cs});
		if (tw < 0) begin
			tw = -tw;
		end
		return tw[30:0];
	endfunction

	function automatic logic [31:0] id_out(input logic [ID_WIDTH-1:0] id);
		logic [ID_WIDTH+31:0] e;
		e = {32'b0, id};
		return e[31:0];
	endfunction

	function automatic logic [15:0] cell_out(input logic [CW-1:0] idx);
		logic [CW+15:0] e;
		e = {16'b0, idx};
		return e[15:0];
	endfunction

	// Configuration
	logic signed [31:0] org_x_q, org_y_q, org_z_q;
	logic [30:0]        cs_q;
	logic [16:0]        nx_q, ny_q, nz_q;
	logic [30:0]        cs_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
			cs_q    <= CELL_SIZE_RST;
			nx_q    <= CELLS_RST;
			ny_q    <= CELLS_RST;
			nz_q    <= CELLS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X:  org_x_q <= cfg_wdata;
				REG_ORIGIN_Y:  org_y_q <= cfg_wdata;
				REG_ORIGIN_Z:  org_z_q <= cfg_wdata;
				REG_CELL_SIZE: cs_q    <= cfg_wdata[30:0];
				REG_CELLS_X:   nx_q    <= cfg_wdata[16:0];
				REG_CELLS_Y:   ny_q    <= cfg_wdata[16:0];
				REG_CELLS_Z:   nz_q    <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	// A cell size of zero behaves as the smallest step.
	assign cs_eff = (cs_q == '0) ? 31'd1 : cs_q;

	// Control state
	logic [3:0]      state_q;
	logic [AW-1:0]   clr_q;
	logic [CW-1:0]   cur_q;
	logic [CNTW-1:0] occ_cnt_q;
	logic [AW-1:0]   scan_w_q;
	logic            first_q;
	logic            done_q;
	res_t            res_q;
	logic            accept;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;

	// Datapath registers
	logic [ID_WIDTH-1:0] id_q;
	logic                neg_x_q, neg_y_q, neg_z_q;
	logic [30:0]         ax_q, ay_q, az_q;
	logic [16:0]         cx_q, cy_q, cz_q;
	logic                inb_q;
	logic [33:0]         pxy_q, py_q;
	logic [61:0]         sqx_q, sqy_q, sqz_q;
	logic [50:0]         pz_q;
	logic [63:0]         dist_q;
	logic [CW-1:0]       lin_q;
	logic [CW-1:0]       idx_q;

	// Axis offsets from the grid minimum
	logic signed [32:0] dx, dy, dz;
	logic [ID_WIDTH+31:0] id_ext;

	assign dx = {cmd.x_coord[31], cmd.x_coord} - {org_x_q[31], org_x_q};
	assign dy = {cmd.y_coord[31], cmd.y_coord} - {org_y_q[31], org_y_q};
	assign dz = {cmd.z_coord[31], cmd.z_coord} - {org_z_q[31], org_z_q};
	assign id_ext = {{ID_WIDTH{1'b0}}, cmd.point_id};

	logic        div_start;
	logic        dn_x, dn_y, dn_z;
	logic [31:0] qx, qy, qz;
	logic [30:0] rx, ry, rz;

	assign div_start = accept && (cmd.mode != MODE_FETCH);

	vgnc_divider u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dx[31:0]),
		.divisor(cs_eff), .done(dn_x), .quotient(qx), .remainder(rx)
	);
	vgnc_divider u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dy[31:0]),
		.divisor(cs_eff), .done(dn_y), .quotient(qy), .remainder(ry)
	);
	vgnc_divider u_div_z (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dz[31:0]),
		.divisor(cs_eff), .done(dn_z), .quotient(qz), .remainder(rz)
	);

	// Cell store
	mem_ctl_t      ctl;
	logic [AW-1:0] occ_addr;
	logic [WB-1:0] occ_wdata;
	logic [WB-1:0] occ_rdata;
	logic [CW-1:0] dat_addr;
	logic [DW-1:0] dat_wdata;
	logic [DW-1:0] dat_rdata;

	vgnc_cell_store #(
		.WB(WB), .AW(AW), .NW(NW), .CW(CW), .DEP(MAX_CELLS), .DW(DW)
	) u_store (
		.clk(clk), .ctl(ctl), .occ_addr(occ_addr), .occ_wdata(occ_wdata),
		.occ_rdata(occ_rdata), .dat_addr(dat_addr), .dat_wdata(dat_wdata),
		.dat_rdata(dat_rdata)
	);

	// Linear index and grid membership test
	logic [51:0]   lin_full;
	logic          in_grid;
	logic [CW-1:0] lin_n;

	assign lin_full = 52'(pz_q) + 52'(py_q) + 52'(cx_q);
	assign in_grid  = inb_q && (lin_full < 52'(MAX_CELLS));
	assign lin_n    = lin_full[CW-1:0];

	// Insert decision
	logic                occ_bit;
	logic [ID_WIDTH-1:0] best_id;
	logic [63:0]         best_d;
	logic                closer;

	assign occ_bit = occ_rdata[lin_q[WBL-1:0]];
	assign best_id = dat_rdata[DW-1:64];
	assign best_d  = dat_rdata[63:0];
	assign closer  = dist_q < best_d;

	// Drain search within one bitmap word
	logic [WB-1:0]  masked;
	logic [WBL-1:0] pos;
	logic           found;
	logic [CW-1:0]  idx_n;
	logic [AW-1:0]  next_w;

	always_comb begin
		masked = first_q ? (occ_rdata & ({WB{1'b1}} << cur_q[WBL-1:0])) : occ_rdata;
		pos    = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (masked[i]) begin
				pos = WBL'(i);
			end
		end
	end

	assign found  = |masked;
	assign idx_n  = {scan_w_q, pos};
	assign next_w = (scan_w_q == AW'(NW - 1)) ? '0 : scan_w_q + AW'(1);

	always_comb begin
		ctl       = '0;
		occ_addr  = cur_q[CW-1:WBL];
		occ_wdata = '0;
		dat_addr  = lin_q;
		dat_wdata = {id_q, dist_q};
		case (state_q)
			S_CLEAR: begin
				ctl.occ_we = 1'b1;
				occ_addr   = clr_q;
			end
			S_IDLE: begin
				if (accept && cmd.mode == MODE_FETCH && occ_cnt_q != '0) begin
					ctl.occ_rd = 1'b1;
				end
			end
			S_CHK: begin
				if (in_grid) begin
					ctl.occ_rd = 1'b1;
					ctl.dat_rd = 1'b1;
					occ_addr   = lin_n[CW-1:WBL];
					dat_addr   = lin_n;
				end
			end
			S_UPD: begin
				occ_addr = lin_q[CW-1:WBL];
				if (!occ_bit) begin
					ctl.occ_we = 1'b1;
					ctl.dat_we = 1'b1;
					occ_wdata  = occ_rdata | (WB'(1) << lin_q[WBL-1:0]);
				end else if (closer) begin
					ctl.dat_we = 1'b1;
				end
			end
			S_SCAN: begin
				if (found) begin
					ctl.occ_we = 1'b1;
					ctl.dat_rd = 1'b1;
					occ_addr   = scan_w_q;
					occ_wdata  = occ_rdata & ~(WB'(1) << pos);
					dat_addr   = idx_n;
				end else begin
					ctl.occ_rd = 1'b1;
					occ_addr   = next_w;
				end
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			cur_q     <= '0;
			occ_cnt_q <= '0;
			scan_w_q  <= '0;
			first_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NW - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (cmd.mode != MODE_FETCH) begin
							state_q <= S_DIV;
						end else if (occ_cnt_q == '0) begin
							cur_q  <= '0;
							done_q <= 1'b1;
						end else begin
							scan_w_q <= cur_q[CW-1:WBL];
							first_q  <= 1'b1;
							state_q  <= S_SCAN;
						end
					end
				end
				S_DIV: begin
					if (dn_x && dn_y && dn_z) begin
						state_q <= S_OFF;
					end
				end
				S_OFF: state_q <= S_MUL;
				S_MUL: state_q <= S_SUM;
				S_SUM: state_q <= S_CHK;
				S_CHK: begin
					if (in_grid) begin
						state_q <= S_UPD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_UPD: begin
					if (!occ_bit) begin
						occ_cnt_q <= occ_cnt_q + CNTW'(1);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (found) begin
						state_q <= S_DOUT;
					end else begin
						scan_w_q <= next_w;
						first_q  <= 1'b0;
					end
				end
				S_DOUT: begin
					occ_cnt_q <= occ_cnt_q - CNTW'(1);
					if (occ_cnt_q == CNTW'(1) || idx_q == CW'(MAX_CELLS - 1)) begin
						cur_q <= '0;
					end else begin
						cur_q <= idx_q + CW'(1);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath and result word
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				id_q    <= id_ext[ID_WIDTH-1:0];
				neg_x_q <= dx[32];
				neg_y_q <= dy[32];
				neg_z_q <= dz[32];
				res_q   <= '{status: ST_DRAIN, kept_id: '0, cell_number: '0, last: 1'b1};
			end
			S_OFF: begin
				ax_q  <= half_off(rx, cs_eff);
				ay_q  <= half_off(ry, cs_eff);
				az_q  <= half_off(rz, cs_eff);
				cx_q  <= qx[16:0];
				cy_q  <= qy[16:0];
				cz_q  <= qz[16:0];
				inb_q <= !neg_x_q && !neg_y_q && !neg_z_q &&
				         (qx < {15'b0, nx_q}) && (qy < {15'b0, ny_q}) &&
				         (qz < {15'b0, nz_q});
				pxy_q <= 34'(nx_q) * 34'(ny_q);
			end
			S_MUL: begin
				sqx_q <= 62'(ax_q) * 62'(ax_q);
				sqy_q <= 62'(ay_q) * 62'(ay_q);
				sqz_q <= 62'(az_q) * 62'(az_q);
				py_q  <= 34'(cy_q) * 34'(nx_q);
			end
			S_SUM: begin
				pz_q   <= 51'(cz_q) * 51'(pxy_q);
				dist_q <= 64'(sqx_q) + 64'(sqy_q) + 64'(sqz_q);
			end
			S_CHK: begin
				lin_q <= lin_n;
				res_q <= '{status: ST_OUTSIDE, kept_id: '0, cell_number: '0, last: 1'b0};
			end
			S_UPD: begin
				res_q.cell_number <= cell_out(lin_q);
				res_q.last        <= 1'b0;
				if (!occ_bit) begin
					res_q.status  <= ST_NEW;
					res_q.kept_id <= id_out(id_q);
				end else if (closer) begin
					res_q.status  <= ST_REPLACE;
					res_q.kept_id <= id_out(id_q);
				end else begin
					res_q.status  <= ST_KEEP;
					res_q.kept_id <= id_out(best_id);
				end
			end
			S_SCAN: begin
				idx_q <= idx_n;
			end
			S_DOUT: begin
				res_q.status      <= ST_DRAIN;
				res_q.kept_id     <= id_out(best_id);
				res_q.cell_number <= cell_out(idx_q);
				res_q.last        <= occ_cnt_q == CNTW'(1);
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

	// No result word may appear while the bitmap is still being cleared.
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !done_q)
		else $error("result strobed during clearing pass");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_cnt_q <= CNTW'(MAX_CELLS))
		else $error("occupancy count above grid capacity");

	// A final drained word means the grid is now empty.
	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.status == ST_DRAIN && res_q.last) |-> (occ_cnt_q == '0))
		else $error("last drain word with occupied cells left");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done_q))
		else $error("accepted word neither in progress nor answered");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy || accept))
		else $error("result strobe without a word in progress");

endmodule
